/* design/etmm_pkg.sv */
// Shared constants and types for the Euler TRS model matrix core.
`default_nettype none
package etmm_pkg;
	// Number formats
	localparam int FRAC_BITS = 16;
	localparam int TRIG_BITS = 30;
	localparam int ANG_W = 26;
	localparam int VAL_W = 32;

	// Angle reduction
	localparam int FULL_DEG = 360 << FRAC_BITS;
	localparam int QUARTER_DEG = 90 << FRAC_BITS;
	localparam int REM_W = $clog2(QUARTER_DEG);
	localparam int RED_W = ANG_W + 1;

	// Degrees to radians, pi/180 * 2^38
	localparam int K_W = 33;
	localparam logic [K_W-1:0] DEG2RAD_K = 33'd4797524517;
	localparam int RAD_SHIFT = FRAC_BITS + 8;
	localparam int XM_W = REM_W + K_W;

	// Series datapath widths
	localparam int X_W = TRIG_BITS + 1;
	localparam int X2_W = TRIG_BITS + 2;
	localparam int T_W = TRIG_BITS + 1;
	localparam int P_W = 32;
	localparam int RECIP_SHIFT = 32;
	localparam logic [P_W-1:0] T_ONE = P_W'(64'd1 << TRIG_BITS);

	// Horner divisors, innermost first
	localparam int N_SLOT = 6;
	localparam int N_SIN = 5;
	localparam int unsigned COS_K [N_SLOT] = '{132, 90, 56, 30, 12, 2};
	localparam int unsigned SIN_K [N_SIN] = '{110, 72, 42, 20, 6};

	// Quadrant codes
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Pipeline depths
	localparam int TRIG_LAT = 3 + 3 * N_SLOT + 1;
	localparam int BACK_LAT = 5;
	localparam int PIPE_LAT = TRIG_LAT + BACK_LAT;
	localparam int SCALE_TAP = TRIG_LAT + 2;

	// Queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [TRIG_BITS+1:0] trig_t;
	typedef logic signed [TRIG_BITS+2:0] ent_t;

	typedef struct packed {
		val_t pos_x;
		val_t pos_y;
		val_t pos_z;
		logic signed [ANG_W-1:0] angle_x;
		logic signed [ANG_W-1:0] angle_y;
		logic signed [ANG_W-1:0] angle_z;
		val_t scale_x;
		val_t scale_y;
		val_t scale_z;
	} obj_t;

	typedef struct packed {
		val_t pos_x;
		val_t pos_y;
		val_t pos_z;
		val_t scale_x;
		val_t scale_y;
		val_t scale_z;
	} side_t;

	typedef struct packed {
		side_t side;
		logic [1:0] qx;
		logic [1:0] qy;
		logic [1:0] qz;
		logic [REM_W-1:0] rx;
		logic [REM_W-1:0] ry;
		logic [REM_W-1:0] rz;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		val_t row0_col0;
		val_t row0_col1;
		val_t row0_col2;
		val_t row0_col3;
		val_t row1_col0;
		val_t row1_col1;
		val_t row1_col2;
		val_t row1_col3;
		val_t row2_col0;
		val_t row2_col1;
		val_t row2_col2;
		val_t row2_col3;
	} mat_t;
endpackage
`default_nettype wire

/* design/etmm_fifo.sv */
// Short item queue between the front stage and the matrix pipeline.
`default_nettype none
module etmm_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  etmm_pkg::item_t          wr_item,
	input  wire logic                pop,
	output etmm_pkg::item_t          rd_item,
	output etmm_pkg::fifo_stat_t     stat
);
	etmm_pkg::item_t mem_q [etmm_pkg::FIFO_DEPTH];
	logic [etmm_pkg::PTR_W-1:0] wp_q;
	logic [etmm_pkg::PTR_W-1:0] rp_q;
	logic [etmm_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_item;
	end

	assign rd_item = mem_q[rp_q];
	assign stat.full = (cnt_q == etmm_pkg::CNT_W'(etmm_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue read while empty");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a write");
endmodule
`default_nettype wire

/* design/etmm_front.sv */
// Front stage: takes items, reduces angles to quadrant and remainder, feeds the queue.
`default_nettype none
module etmm_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                obj_valid,
	output logic                     obj_stall,
	input  etmm_pkg::obj_t           obj,
	output logic                     push,
	output etmm_pkg::item_t          item,
	input  etmm_pkg::fifo_stat_t     stat
);
	localparam logic signed [etmm_pkg::RED_W-1:0] FULL_S =
		etmm_pkg::RED_W'(etmm_pkg::FULL_DEG);
	localparam logic signed [etmm_pkg::RED_W-1:0] QTR_S =
		etmm_pkg::RED_W'(etmm_pkg::QUARTER_DEG);

	logic fv_q;
	etmm_pkg::item_t item_q;
	etmm_pkg::item_t item_d;
	logic take;

	// angle mod 360 into [0, 360), then quadrant and remainder
	function automatic logic [etmm_pkg::REM_W+1:0] reduce_angle(
		input logic signed [etmm_pkg::ANG_W-1:0] ang);
		logic signed [etmm_pkg::RED_W-1:0] a0;
		logic signed [etmm_pkg::RED_W-1:0] a;
		logic signed [etmm_pkg::RED_W-1:0] r;
		logic [1:0] q;
		a0 = etmm_pkg::RED_W'(ang);
		if (a0 >= FULL_S)
			a = a0 - FULL_S;
		else if (a0 >= 0)
			a = a0;
		else if (a0 + FULL_S >= 0)
			a = a0 + FULL_S;
		else
			a = a0 + FULL_S + FULL_S;
		if (a >= QTR_S + QTR_S + QTR_S) begin
			q = etmm_pkg::QUAD_3;
			r = a - QTR_S - QTR_S - QTR_S;
		end else if (a >= QTR_S + QTR_S) begin
			q = etmm_pkg::QUAD_2;
			r = a - QTR_S - QTR_S;
		end else if (a >= QTR_S) begin
			q = etmm_pkg::QUAD_1;
			r = a - QTR_S;
		end else begin
			q = etmm_pkg::QUAD_0;
			r = a;
		end
		return {q, r[etmm_pkg::REM_W-1:0]};
	endfunction

	always_comb begin
		item_d.side.pos_x = obj.pos_x;
		item_d.side.pos_y = obj.pos_y;
		item_d.side.pos_z = obj.pos_z;
		item_d.side.scale_x = obj.scale_x;
		item_d.side.scale_y = obj.scale_y;
		item_d.side.scale_z = obj.scale_z;
		{item_d.qx, item_d.rx} = reduce_angle(obj.angle_x);
		{item_d.qy, item_d.ry} = reduce_angle(obj.angle_y);
		{item_d.qz, item_d.rz} = reduce_angle(obj.angle_z);
	end

	assign obj_stall = fv_q && stat.full;
	assign take = obj_valid && !obj_stall;
	assign push = fv_q && !stat.full;
	assign item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fv_q <= 1'b0;
		else if (take)
			fv_q <= 1'b1;
		else if (push)
			fv_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			item_q <= item_d;
	end
endmodule
`default_nettype wire

/* design/etmm_trig.sv */
// Pipelined sine/cosine of one reduced angle: radians, Horner series, quadrant map.
`default_nettype none
module etmm_trig (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [1:0]                        q,
	input  wire logic [etmm_pkg::REM_W-1:0]        r,
	output etmm_pkg::trig_t                        s,
	output etmm_pkg::trig_t                        c
);
	localparam int XX_W = 2 * etmm_pkg::X_W;
	localparam int TP_W = etmm_pkg::X2_W + etmm_pkg::T_W;
	localparam int MP_W = 2 * etmm_pkg::P_W;
	localparam int SP_W = etmm_pkg::X_W + etmm_pkg::T_W;

	logic [etmm_pkg::XM_W-1:0] rad_s1;
	logic [1:0] quad_s1;
	logic [etmm_pkg::X_W-1:0] rad_s2;
	logic [XX_W-1:0] sq_s2;
	logic [1:0] quad_s2;
	logic [etmm_pkg::X_W-1:0] rad_s3;
	logic [etmm_pkg::X2_W-1:0] rsq_s3;
	logic [1:0] quad_s3;
	logic [etmm_pkg::X_W-1:0] rad_w;

	logic [etmm_pkg::X2_W-1:0] slot_x2_s3 [etmm_pkg::N_SLOT];
	logic [etmm_pkg::X_W-1:0] slot_x_s3 [etmm_pkg::N_SLOT];
	logic [1:0] slot_q_s3 [etmm_pkg::N_SLOT];
	logic [etmm_pkg::T_W-1:0] slot_ts_s3 [etmm_pkg::N_SLOT];
	logic [etmm_pkg::T_W-1:0] slot_tc_s3 [etmm_pkg::N_SLOT];

	logic [SP_W-1:0] sprod;
	etmm_pkg::trig_t sv;
	etmm_pkg::trig_t cv;

	assign rad_w = rad_s1[etmm_pkg::RAD_SHIFT +: etmm_pkg::X_W];

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= etmm_pkg::XM_W'(r) * etmm_pkg::XM_W'(etmm_pkg::DEG2RAD_K);
			quad_s1 <= q;
			rad_s2 <= rad_w;
			sq_s2 <= XX_W'(rad_w) * XX_W'(rad_w);
			quad_s2 <= quad_s1;
			rad_s3 <= rad_s2;
			rsq_s3 <= sq_s2[etmm_pkg::TRIG_BITS +: etmm_pkg::X2_W];
			quad_s3 <= quad_s2;
		end
	end

	// one Horner step per slot, three stages each: product, reciprocal, correction
	for (genvar i = 0; i < etmm_pkg::N_SLOT; i++) begin : g_slot
		localparam logic [etmm_pkg::P_W-1:0] KC = etmm_pkg::P_W'(etmm_pkg::COS_K[i]);
		localparam logic [etmm_pkg::P_W-1:0] MC =
			etmm_pkg::P_W'((64'd1 << etmm_pkg::RECIP_SHIFT) / etmm_pkg::COS_K[i]);

		logic [etmm_pkg::X2_W-1:0] x2_in;
		logic [etmm_pkg::X_W-1:0] x_in;
		logic [1:0] q_in;
		logic [etmm_pkg::T_W-1:0] ts_in;
		logic [etmm_pkg::T_W-1:0] tc_in;
		logic [TP_W-1:0] tpc;
		logic [MP_W-1:0] mpc;

		logic [etmm_pkg::X2_W-1:0] x2_s1;
		logic [etmm_pkg::X_W-1:0] x_s1;
		logic [1:0] q_s1;
		logic [etmm_pkg::P_W-1:0] pc_s1;
		logic [etmm_pkg::X2_W-1:0] x2_s2;
		logic [etmm_pkg::X_W-1:0] x_s2;
		logic [1:0] q_s2;
		logic [etmm_pkg::P_W-1:0] pc_s2;
		logic [etmm_pkg::P_W-1:0] qc_s2;
		logic [etmm_pkg::P_W-1:0] remc;
		logic [etmm_pkg::P_W-1:0] dc;

		if (i == 0) begin : g_first
			assign x2_in = rsq_s3;
			assign x_in = rad_s3;
			assign q_in = quad_s3;
			assign ts_in = etmm_pkg::T_W'(etmm_pkg::T_ONE);
			assign tc_in = etmm_pkg::T_W'(etmm_pkg::T_ONE);
		end else begin : g_next
			assign x2_in = slot_x2_s3[i-1];
			assign x_in = slot_x_s3[i-1];
			assign q_in = slot_q_s3[i-1];
			assign ts_in = slot_ts_s3[i-1];
			assign tc_in = slot_tc_s3[i-1];
		end

		assign tpc = TP_W'(x2_in) * TP_W'(tc_in);
		assign mpc = MP_W'(pc_s1) * MP_W'(MC);
		assign remc = pc_s2 - etmm_pkg::P_W'(qc_s2 * KC);
		assign dc = (remc >= KC) ? qc_s2 + 1'b1 : qc_s2;

		always_ff @(posedge clk) begin
			if (en) begin
				x2_s1 <= x2_in;
				x_s1 <= x_in;
				q_s1 <= q_in;
				pc_s1 <= tpc[etmm_pkg::TRIG_BITS +: etmm_pkg::P_W];
				x2_s2 <= x2_s1;
				x_s2 <= x_s1;
				q_s2 <= q_s1;
				pc_s2 <= pc_s1;
				qc_s2 <= mpc[etmm_pkg::RECIP_SHIFT +: etmm_pkg::P_W];
				slot_x2_s3[i] <= x2_s2;
				slot_x_s3[i] <= x_s2;
				slot_q_s3[i] <= q_s2;
				slot_tc_s3[i] <= (dc >= etmm_pkg::T_ONE) ? '0 :
					etmm_pkg::T_W'(etmm_pkg::T_ONE - dc);
			end
		end

		if (i < etmm_pkg::N_SIN) begin : g_sin
			localparam logic [etmm_pkg::P_W-1:0] KS = etmm_pkg::P_W'(etmm_pkg::SIN_K[i]);
			localparam logic [etmm_pkg::P_W-1:0] MS =
				etmm_pkg::P_W'((64'd1 << etmm_pkg::RECIP_SHIFT) / etmm_pkg::SIN_K[i]);
			logic [TP_W-1:0] tps;
			logic [MP_W-1:0] mps;
			logic [etmm_pkg::P_W-1:0] ps_s1;
			logic [etmm_pkg::P_W-1:0] ps_s2;
			logic [etmm_pkg::P_W-1:0] qs_s2;
			logic [etmm_pkg::P_W-1:0] rems;
			logic [etmm_pkg::P_W-1:0] ds;

			assign tps = TP_W'(x2_in) * TP_W'(ts_in);
			assign mps = MP_W'(ps_s1) * MP_W'(MS);
			assign rems = ps_s2 - etmm_pkg::P_W'(qs_s2 * KS);
			assign ds = (rems >= KS) ? qs_s2 + 1'b1 : qs_s2;

			always_ff @(posedge clk) begin
				if (en) begin
					ps_s1 <= tps[etmm_pkg::TRIG_BITS +: etmm_pkg::P_W];
					ps_s2 <= ps_s1;
					qs_s2 <= mps[etmm_pkg::RECIP_SHIFT +: etmm_pkg::P_W];
					slot_ts_s3[i] <= (ds >= etmm_pkg::T_ONE) ? '0 :
						etmm_pkg::T_W'(etmm_pkg::T_ONE - ds);
				end
			end
		end else begin : g_pad
			// sine series is one term shorter: hold it for the slot
			logic [etmm_pkg::T_W-1:0] ts_s1;
			logic [etmm_pkg::T_W-1:0] ts_s2;
			always_ff @(posedge clk) begin
				if (en) begin
					ts_s1 <= ts_in;
					ts_s2 <= ts_s1;
					slot_ts_s3[i] <= ts_s2;
				end
			end
		end
	end

	assign sprod = SP_W'(slot_x_s3[etmm_pkg::N_SLOT-1]) *
		SP_W'(slot_ts_s3[etmm_pkg::N_SLOT-1]);
	assign sv = etmm_pkg::trig_t'({1'b0, sprod[etmm_pkg::TRIG_BITS +: etmm_pkg::X_W]});
	assign cv = etmm_pkg::trig_t'({1'b0, slot_tc_s3[etmm_pkg::N_SLOT-1]});

	always_ff @(posedge clk) begin
		if (en) begin
			case (slot_q_s3[etmm_pkg::N_SLOT-1])
				etmm_pkg::QUAD_0: begin
					s <= sv;
					c <= cv;
				end
				etmm_pkg::QUAD_1: begin
					s <= cv;
					c <= -sv;
				end
				etmm_pkg::QUAD_2: begin
					s <= -sv;
					c <= -cv;
				end
				etmm_pkg::QUAD_3: begin
					s <= -cv;
					c <= sv;
				end
				default: begin
					s <= sv;
					c <= cv;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/etmm_back.sv */
// Back pipeline: pops queued items, builds rotation, scales and saturates the matrix.
`default_nettype none
module etmm_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  etmm_pkg::item_t          head,
	input  etmm_pkg::fifo_stat_t     stat,
	output logic                     pop,
	output logic                     mat_valid,
	input  wire logic                mat_stall,
	output etmm_pkg::mat_t           mat
);
	localparam int N_ENT = 9;
	localparam int PR_W = 64;
	localparam int RND_W = PR_W - etmm_pkg::TRIG_BITS;
	localparam logic signed [PR_W-1:0] HALF = PR_W'(64'd1 << (etmm_pkg::TRIG_BITS - 1));
	localparam logic signed [RND_W-1:0] VMAX = RND_W'(64'sh7FFFFFFF);
	localparam logic signed [RND_W-1:0] VMIN = -RND_W'(64'sh80000000);

	logic adv;
	logic [etmm_pkg::PIPE_LAT-1:0] vld_q;
	etmm_pkg::side_t side_q [etmm_pkg::PIPE_LAT];
	etmm_pkg::trig_t sx, cx, sy, cy, sz, cz;

	etmm_pkg::trig_t sxsz_s23, sxcz_s23, cycz_s23, cysz_s23, sycx_s23;
	etmm_pkg::trig_t cxsz_s23, cxcz_s23, cycx_s23, sysz_s23, sycz_s23;
	etmm_pkg::trig_t sx_s23, sy_s23, cy_s23;
	etmm_pkg::trig_t syxs_s24, syxc_s24, cyxs_s24, cyxc_s24;
	etmm_pkg::trig_t cycz_s24, cysz_s24, sycx_s24, cxsz_s24;
	etmm_pkg::trig_t cxcz_s24, cycx_s24, sysz_s24, sycz_s24, sx_s24;
	etmm_pkg::ent_t ent_s25 [N_ENT];
	logic signed [PR_W-1:0] prod_s26 [N_ENT];
	etmm_pkg::val_t mat_s27 [N_ENT];
	etmm_pkg::val_t col_scale [3];

	function automatic etmm_pkg::trig_t tmul(input etmm_pkg::trig_t a,
		input etmm_pkg::trig_t b);
		logic signed [PR_W-1:0] p;
		p = PR_W'(a) * PR_W'(b) + HALF;
		return etmm_pkg::trig_t'(p >>> etmm_pkg::TRIG_BITS);
	endfunction

	function automatic etmm_pkg::val_t sat_round(input logic signed [PR_W-1:0] p);
		logic signed [RND_W-1:0] v;
		v = RND_W'((p + HALF) >>> etmm_pkg::TRIG_BITS);
		if (v > VMAX)
			return etmm_pkg::val_t'(VMAX);
		else if (v < VMIN)
			return etmm_pkg::val_t'(VMIN);
		else
			return etmm_pkg::val_t'(v);
	endfunction

	assign adv = !vld_q[etmm_pkg::PIPE_LAT-1] || !mat_stall;
	assign pop = adv && !stat.empty;

	etmm_trig u_trig_x (.clk(clk), .en(adv), .q(head.qx), .r(head.rx), .s(sx), .c(cx));
	etmm_trig u_trig_y (.clk(clk), .en(adv), .q(head.qy), .r(head.ry), .s(sy), .c(cy));
	etmm_trig u_trig_z (.clk(clk), .en(adv), .q(head.qz), .r(head.rz), .s(sz), .c(cz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[etmm_pkg::PIPE_LAT-2:0], pop};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= head.side;
			for (int i = 1; i < etmm_pkg::PIPE_LAT; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	assign col_scale[0] = side_q[etmm_pkg::SCALE_TAP].scale_x;
	assign col_scale[1] = side_q[etmm_pkg::SCALE_TAP].scale_y;
	assign col_scale[2] = side_q[etmm_pkg::SCALE_TAP].scale_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			sxsz_s23 <= tmul(sx, sz);
			sxcz_s23 <= tmul(sx, cz);
			cycz_s23 <= tmul(cy, cz);
			cysz_s23 <= tmul(cy, sz);
			sycx_s23 <= tmul(sy, cx);
			cxsz_s23 <= tmul(cx, sz);
			cxcz_s23 <= tmul(cx, cz);
			cycx_s23 <= tmul(cy, cx);
			sysz_s23 <= tmul(sy, sz);
			sycz_s23 <= tmul(sy, cz);
			sx_s23 <= sx;
			sy_s23 <= sy;
			cy_s23 <= cy;

			syxs_s24 <= tmul(sy_s23, sxsz_s23);
			syxc_s24 <= tmul(sy_s23, sxcz_s23);
			cyxs_s24 <= tmul(cy_s23, sxsz_s23);
			cyxc_s24 <= tmul(cy_s23, sxcz_s23);
			cycz_s24 <= cycz_s23;
			cysz_s24 <= cysz_s23;
			sycx_s24 <= sycx_s23;
			cxsz_s24 <= cxsz_s23;
			cxcz_s24 <= cxcz_s23;
			cycx_s24 <= cycx_s23;
			sysz_s24 <= sysz_s23;
			sycz_s24 <= sycz_s23;
			sx_s24 <= sx_s23;

			// R = Ry * Rx * Rz, row-major
			ent_s25[0] <= etmm_pkg::ent_t'(cycz_s24) + etmm_pkg::ent_t'(syxs_s24);
			ent_s25[1] <= etmm_pkg::ent_t'(syxc_s24) - etmm_pkg::ent_t'(cysz_s24);
			ent_s25[2] <= etmm_pkg::ent_t'(sycx_s24);
			ent_s25[3] <= etmm_pkg::ent_t'(cxsz_s24);
			ent_s25[4] <= etmm_pkg::ent_t'(cxcz_s24);
			ent_s25[5] <= -etmm_pkg::ent_t'(sx_s24);
			ent_s25[6] <= etmm_pkg::ent_t'(cyxs_s24) - etmm_pkg::ent_t'(sycz_s24);
			ent_s25[7] <= etmm_pkg::ent_t'(sysz_s24) + etmm_pkg::ent_t'(cyxc_s24);
			ent_s25[8] <= etmm_pkg::ent_t'(cycx_s24);

			for (int i = 0; i < N_ENT; i++) begin
				prod_s26[i] <= PR_W'(ent_s25[i]) * PR_W'(col_scale[i % 3]);
				mat_s27[i] <= sat_round(prod_s26[i]);
			end
		end
	end

	assign mat_valid = vld_q[etmm_pkg::PIPE_LAT-1];
	assign mat.row0_col0 = mat_s27[0];
	assign mat.row0_col1 = mat_s27[1];
	assign mat.row0_col2 = mat_s27[2];
	assign mat.row0_col3 = side_q[etmm_pkg::PIPE_LAT-1].pos_x;
	assign mat.row1_col0 = mat_s27[3];
	assign mat.row1_col1 = mat_s27[4];
	assign mat.row1_col2 = mat_s27[5];
	assign mat.row1_col3 = side_q[etmm_pkg::PIPE_LAT-1].pos_y;
	assign mat.row2_col0 = mat_s27[6];
	assign mat.row2_col1 = mat_s27[7];
	assign mat.row2_col2 = mat_s27[8];
	assign mat.row2_col3 = side_q[etmm_pkg::PIPE_LAT-1].pos_z;
endmodule
`default_nettype wire

/* design/euler_trs_model_matrix_core.sv */
// Top level of the Euler TRS model matrix core (T * Ry * Rx * Rz * S).
// An accepted item passes the front register, the queue and then the back pipeline.
// Throughput: one item per cycle while mat_stall is low; every sine/cosine step and
// product is its own stage. Front stage and result pipeline are parted by a four-entry
// queue, so input keeps flowing until it fills while a finished result waits under stall.
// Reset: arst_n clears all valid bits and queue pointers; datapath registers are not reset.
`default_nettype none
module euler_trs_model_matrix_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// item side
	input  wire logic                                obj_valid,
	output logic                                     obj_stall,
	input  wire logic signed [etmm_pkg::VAL_W-1:0]   pos_x,
	input  wire logic signed [etmm_pkg::VAL_W-1:0]   pos_y,
	input  wire logic signed [etmm_pkg::VAL_W-1:0]   pos_z,
	input  wire logic signed [etmm_pkg::ANG_W-1:0]   angle_x,
	input  wire logic signed [etmm_pkg::ANG_W-1:0]   angle_y,
	input  wire logic signed [etmm_pkg::ANG_W-1:0]   angle_z,
	input  wire logic signed [etmm_pkg::VAL_W-1:0]   scale_x,
	input  wire logic signed [etmm_pkg::VAL_W-1:0]   scale_y,
	input  wire logic signed [etmm_pkg::VAL_W-1:0]   scale_z,
	// result side
	output logic                                     mat_valid,
	input  wire logic                                mat_stall,
	output logic signed [etmm_pkg::VAL_W-1:0]        row0_col0,
	output logic signed [etmm_pkg::VAL_W-1:0]        row0_col1,
	output logic signed [etmm_pkg::VAL_W-1:0]        row0_col2,
	output logic signed [etmm_pkg::VAL_W-1:0]        row0_col3,
	output logic signed [etmm_pkg::VAL_W-1:0]        row1_col0,
	output logic signed [etmm_pkg::VAL_W-1:0]        row1_col1,
	output logic signed [etmm_pkg::VAL_W-1:0]        row1_col2,
	output logic signed [etmm_pkg::VAL_W-1:0]        row1_col3,
	output logic signed [etmm_pkg::VAL_W-1:0]        row2_col0,
	output logic signed [etmm_pkg::VAL_W-1:0]        row2_col1,
	output logic signed [etmm_pkg::VAL_W-1:0]        row2_col2,
	output logic signed [etmm_pkg::VAL_W-1:0]        row2_col3
);
	etmm_pkg::obj_t obj;
	etmm_pkg::item_t push_item;
	etmm_pkg::item_t head_item;
	etmm_pkg::fifo_stat_t stat;
	etmm_pkg::mat_t mat;
	logic push;
	logic pop;

	// gather the item fields
	assign obj.pos_x = pos_x;
	assign obj.pos_y = pos_y;
	assign obj.pos_z = pos_z;
	assign obj.angle_x = angle_x;
	assign obj.angle_y = angle_y;
	assign obj.angle_z = angle_z;
	assign obj.scale_x = scale_x;
	assign obj.scale_y = scale_y;
	assign obj.scale_z = scale_z;

	// front: angle reduction to quadrant + remainder, one register stage
	etmm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.obj_valid(obj_valid),
		.obj_stall(obj_stall),
		.obj(obj),
		.push(push),
		.item(push_item),
		.stat(stat)
	);

	// decoupling queue
	etmm_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_item(push_item),
		.pop(pop),
		.rd_item(head_item),
		.stat(stat)
	);

	// back: 22-stage sine/cosine lanes, then 5 stages of matrix build, scale, saturate;
	// the whole pipe advances unless a held result is stalled
	etmm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head_item),
		.stat(stat),
		.pop(pop),
		.mat_valid(mat_valid),
		.mat_stall(mat_stall),
		.mat(mat)
	);

	assign row0_col0 = mat.row0_col0;
	assign row0_col1 = mat.row0_col1;
	assign row0_col2 = mat.row0_col2;
	assign row0_col3 = mat.row0_col3;
	assign row1_col0 = mat.row1_col0;
	assign row1_col1 = mat.row1_col1;
	assign row1_col2 = mat.row1_col2;
	assign row1_col3 = mat.row1_col3;
	assign row2_col0 = mat.row2_col0;
	assign row2_col1 = mat.row2_col1;
	assign row2_col2 = mat.row2_col2;
	assign row2_col3 = mat.row2_col3;
endmodule
`default_nettype wire

/* tb/sv/tb_euler_trs_model_matrix_core.sv */
// Self-checking testbench for the Euler TRS model matrix core.
`timescale 1ns / 100ps
`default_nettype none
module tb_euler_trs_model_matrix_core;
	localparam longint FULL_Q = 64'sd360 << 16;
	localparam longint QUART_Q = 64'sd90 << 16;
	localparam longint UNIT_Q = 64'sd1 << 16;
	localparam longint DEG_K = 64'd4797524517;
	localparam longint TRIG_UNIT = 64'sd1 << 30;
	localparam int LAT_CYC = 28;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic obj_valid = 1'b0;
	logic obj_stall;
	etmm_pkg::val_t pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [etmm_pkg::ANG_W-1:0] angle_x = '0, angle_y = '0, angle_z = '0;
	etmm_pkg::val_t scale_x = '0, scale_y = '0, scale_z = '0;
	logic mat_valid;
	logic mat_stall = 1'b0;
	etmm_pkg::val_t row0_col0, row0_col1, row0_col2, row0_col3;
	etmm_pkg::val_t row1_col0, row1_col1, row1_col2, row1_col3;
	etmm_pkg::val_t row2_col0, row2_col1, row2_col2, row2_col3;

	// Idle odds, out of a hundred, for each side
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// Long hold-off of the result side, in cycles
	int hold_cycles = 0;
	int errors = 0;
	etmm_pkg::mat_t matrix_q[$];

	euler_trs_model_matrix_core dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Rounded arithmetic shift, halves going up
	function automatic longint rshift_round(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint trig_mul(longint a, longint b);
		return rshift_round(a * b, 30);
	endfunction

	function automatic longint horner(longint x2, longint t, longint k);
		longint d;
		d = ((x2 * t) >>> 30) / k;
		return (d >= TRIG_UNIT) ? 64'sd0 : TRIG_UNIT - d;
	endfunction

	// Whole degrees as a signed Q10.16 angle field
	function automatic logic signed [etmm_pkg::ANG_W-1:0] deg(int d);
		return etmm_pkg::ANG_W'(d * 65536);
	endfunction

	// Sine and cosine of an angle in degrees, Q30
	task automatic trig_of(input logic signed [etmm_pkg::ANG_W-1:0] ang, output longint s,
			output longint c);
		longint a, q, r, x, x2, t, sv, cv;
		a = longint'(ang) % FULL_Q;
		if (a < 0) a += FULL_Q;
		q = a / QUART_Q;
		r = a - q * QUART_Q;
		x = (r * DEG_K) >>> 24;
		x2 = (x * x) >>> 30;
		t = horner(x2, TRIG_UNIT, 110);
		t = horner(x2, t, 72);
		t = horner(x2, t, 42);
		t = horner(x2, t, 20);
		t = horner(x2, t, 6);
		sv = (x * t) >>> 30;
		t = horner(x2, TRIG_UNIT, 132);
		t = horner(x2, t, 90);
		t = horner(x2, t, 56);
		t = horner(x2, t, 30);
		t = horner(x2, t, 12);
		cv = horner(x2, t, 2);
		case (q[1:0])
			etmm_pkg::QUAD_0: begin s = sv; c = cv; end
			etmm_pkg::QUAD_1: begin s = cv; c = -sv; end
			etmm_pkg::QUAD_2: begin s = -sv; c = -cv; end
			default: begin s = -cv; c = sv; end
		endcase
	endtask

	function automatic etmm_pkg::val_t scale_sat(longint e, etmm_pkg::val_t k);
		longint v;
		v = rshift_round(e * longint'(k), 30);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return etmm_pkg::val_t'(v);
	endfunction

	task automatic predict_matrix(input etmm_pkg::obj_t o, output etmm_pkg::mat_t m);
		longint sx, cx, sy, cy, sz, cz, sxsz, sxcz;
		trig_of(o.angle_x, sx, cx);
		trig_of(o.angle_y, sy, cy);
		trig_of(o.angle_z, sz, cz);
		sxsz = trig_mul(sx, sz);
		sxcz = trig_mul(sx, cz);
		m.row0_col0 = scale_sat(trig_mul(cy, cz) + trig_mul(sy, sxsz), o.scale_x);
		m.row0_col1 = scale_sat(trig_mul(sy, sxcz) - trig_mul(cy, sz), o.scale_y);
		m.row0_col2 = scale_sat(trig_mul(sy, cx), o.scale_z);
		m.row0_col3 = o.pos_x;
		m.row1_col0 = scale_sat(trig_mul(cx, sz), o.scale_x);
		m.row1_col1 = scale_sat(trig_mul(cx, cz), o.scale_y);
		m.row1_col2 = scale_sat(-sx, o.scale_z);
		m.row1_col3 = o.pos_y;
		m.row2_col0 = scale_sat(trig_mul(cy, sxsz) - trig_mul(sy, cz), o.scale_x);
		m.row2_col1 = scale_sat(trig_mul(sy, sz) + trig_mul(cy, sxcz), o.scale_y);
		m.row2_col2 = scale_sat(trig_mul(cy, cx), o.scale_z);
		m.row2_col3 = o.pos_z;
	endtask

	// Offer one item, holding it until the core takes it; valid stays up for the next
	task automatic send_object(input etmm_pkg::obj_t o);
		etmm_pkg::mat_t m;
		while (($urandom_range(99) < send_idle_pct)) begin
			obj_valid <= 1'b0;
			@(negedge clk);
		end
		predict_matrix(o, m);
		obj_valid <= 1'b1;
		{pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z} <= o;
		do @(posedge clk); while (obj_stall);
		matrix_q.push_back(m);
		@(negedge clk);
	endtask

	// Wait for the core to drain, then let the pipe settle
	task automatic drain();
		obj_valid <= 1'b0;
		while (matrix_q.size() != 0) @(negedge clk);
		repeat (LAT_CYC + 4) @(negedge clk);
	endtask

	function automatic logic signed [etmm_pkg::ANG_W-1:0] rand_angle();
		case ($urandom_range(3))
			0: return etmm_pkg::ANG_W'($urandom);
			1: return etmm_pkg::ANG_W'(longint'($urandom_range(0, 47185920)) - 64'sd23592960);
			2: return etmm_pkg::ANG_W'(longint'($urandom_range(0, 8)) * QUART_Q);
			default: return etmm_pkg::ANG_W'(-longint'($urandom_range(0, 8)) * QUART_Q);
		endcase
	endfunction

	function automatic etmm_pkg::val_t rand_scale();
		case ($urandom_range(3))
			0: return etmm_pkg::val_t'($urandom);
			1: return etmm_pkg::val_t'(longint'($urandom_range(0, 8 << 16)) - (64'sd4 << 16));
			2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return etmm_pkg::val_t'(UNIT_Q);
		endcase
	endfunction

	function automatic etmm_pkg::obj_t rand_object();
		etmm_pkg::obj_t o;
		o.pos_x = $urandom;
		o.pos_y = $urandom;
		o.pos_z = $urandom;
		o.angle_x = rand_angle();
		o.angle_y = rand_angle();
		o.angle_z = rand_angle();
		o.scale_x = rand_scale();
		o.scale_y = rand_scale();
		o.scale_z = rand_scale();
		return o;
	endfunction

	// Result side: stall at random, or hold off for a counted stretch
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			mat_stall <= 1'b1;
		end else begin
			mat_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Result checker: compare each accepted item with the oldest prediction
	always @(posedge clk) begin
		etmm_pkg::mat_t got, want;
		if (arst_n && mat_valid && !mat_stall) begin
			got = {row0_col0, row0_col1, row0_col2, row0_col3, row1_col0, row1_col1,
				row1_col2, row1_col3, row2_col0, row2_col1, row2_col2, row2_col3};
			if (matrix_q.size() == 0) begin
				$display("%t: unexpected item %h", $time, got);
				errors++;
			end else begin
				want = matrix_q.pop_front();
				for (int i = 0; i < 12; i++) begin
					if (got[32*(11-i) +: 32] !== want[32*(11-i) +: 32]) begin
						$display("%t: entry %0d expected %h got %h", $time, i,
							want[32*(11-i) +: 32], got[32*(11-i) +: 32]);
						errors++;
					end
				end
			end
		end
	end

	// Corners: zero, right and 45-degree angles, wrap past a full turn, saturating scales
	task automatic test_directed();
		etmm_pkg::obj_t o;
		logic signed [etmm_pkg::ANG_W-1:0] angs [10];
		angs = '{deg(0), deg(90), deg(180), deg(270), deg(360), deg(-90), deg(-360),
			deg(360), deg(-360), deg(45)};
		for (int i = 0; i < 10; i++) begin
			o = '{32'sh7fffffff, 32'sh80000000, 0, angs[i], angs[(i + 3) % 10],
				angs[(i + 7) % 10], etmm_pkg::val_t'(UNIT_Q), etmm_pkg::val_t'(UNIT_Q),
				etmm_pkg::val_t'(UNIT_Q)};
			send_object(o);
		end
		// all-ones, most-negative and most-positive angle patterns, the last two beyond a turn
		o = '{-1, 1, 32'sh12345678, '1, {1'b1, {(etmm_pkg::ANG_W-1){1'b0}}},
			{1'b0, {(etmm_pkg::ANG_W-1){1'b1}}},
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
		send_object(o);
		o = '{0, 0, 0, deg(30), deg(60), deg(45), 32'sh80000000, 32'sh7fffffff,
			32'sh80000000};
		send_object(o);
		o = '{0, 0, 0, deg(0), deg(0), deg(0), 0, -1, 1};
		send_object(o);
		drain();
	endtask

	task automatic test_random(input int n, input int sidle, input int rstall);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		for (int i = 0; i < n; i++) send_object(rand_object());
		drain();
	endtask

	// Hold the result side off so the queue fills and the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_cycles = 80;
		for (int i = 0; i < 60; i++) send_object(rand_object());
		drain();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_random(180, 0, 0);
		test_random(170, 51, 0);
		test_random(170, 0, 51);
		test_random(170, 12, 12);
		test_backpressure();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

/* euler_trs_model_matrix_core.f */
design/etmm_pkg.sv
design/etmm_fifo.sv
design/etmm_front.sv
design/etmm_trig.sv
design/etmm_back.sv
design/euler_trs_model_matrix_core.sv
tb/sv/tb_euler_trs_model_matrix_core.sv
